FILE: hw/rtl/sdt_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and keyword table for the sql ddl tokenizer
// no dependencies; imported by every module of the block

package sdt_pkg;

    // sizes
    localparam int KW_ENTRIES            = 101;
    localparam int KW_CHARS              = 11;
    localparam int DEF_MAX_KEYWORD_CHARS = 11;
    localparam int DEF_COUNT_WIDTH       = 16;
    localparam int DEF_QUEUE_DEPTH       = 4;
    localparam int EVENTS_PER_BUNDLE     = 3;

    // token kinds
    localparam logic [3:0] KIND_IDENT    = 4'd0;
    localparam logic [3:0] KIND_KEYWORD  = 4'd1;
    localparam logic [3:0] KIND_NUMBER   = 4'd2;
    localparam logic [3:0] KIND_STRING   = 4'd3;
    localparam logic [3:0] KIND_LPAREN   = 4'd4;
    localparam logic [3:0] KIND_RPAREN   = 4'd5;
    localparam logic [3:0] KIND_COMMA    = 4'd6;
    localparam logic [3:0] KIND_SEMI     = 4'd7;
    localparam logic [3:0] KIND_DOT      = 4'd8;
    localparam logic [3:0] KIND_EQUAL    = 4'd9;
    localparam logic [3:0] KIND_LBRACKET = 4'd10;
    localparam logic [3:0] KIND_RBRACKET = 4'd11;
    localparam logic [3:0] KIND_DCOLON   = 4'd12;
    localparam logic [3:0] KIND_END      = 4'd13;
    localparam logic [3:0] KIND_ERROR    = 4'd14;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_QID   = 2'd1;
    localparam logic [1:0] ERR_STR   = 2'd2;
    localparam logic [1:0] ERR_CHAR  = 2'd3;

    // scanner modes
    typedef enum logic [4:0] {
        SCAN_IDLE,
        SCAN_DASH,
        SCAN_SLASH,
        SCAN_COLON,
        SCAN_NUMDOT,
        SCAN_IDENT,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_EXP0,
        SCAN_EXPD,
        SCAN_QID,
        SCAN_QIDEND,
        SCAN_STR,
        SCAN_STRESC,
        SCAN_STREND,
        SCAN_LINECMT,
        SCAN_BLOCK,
        SCAN_BLOCKSTAR
    } t_scan_mode;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_tok_in;

    // result item
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [6:0]  keyword_index;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [1:0]  error_code;
        logic [7:0]  bad_char;
        logic        last_of_run;
    } t_tok_out;

    // all events caused by one input byte
    typedef struct packed {
        t_tok_out [EVENTS_PER_BUNDLE-1:0] ev;
        logic [1:0]                       cnt;
    } t_bundle;

    // keyword table, alphabetical, right aligned in each entry
    localparam logic [8*KW_CHARS-1:0] KW_TABLE [KW_ENTRIES] = '{
        "action", "all", "alter", "always", "as", "asc", "by", "cache", "cascade",
        "check", "collate", "comments", "commit", "compression", "constraint",
        "constraints", "create", "cycle", "default", "defaults", "deferrable",
        "deferred", "delete", "desc", "distinct", "drop", "enforced", "exclude",
        "excluding", "exists", "extended", "external", "first", "for", "foreign",
        "from", "full", "generated", "global", "hash", "identity", "if",
        "immediate", "in", "include", "including", "increment", "indexes",
        "inherit", "inherits", "initially", "key", "last", "like", "list", "local",
        "main", "match", "maxvalue", "minvalue", "modulus", "no", "not", "null",
        "nulls", "of", "oids", "on", "overlaps", "owned", "partial", "partition",
        "period", "plain", "preserve", "primary", "range", "references",
        "remainder", "restrict", "rows", "set", "simple", "start", "statistics",
        "storage", "stored", "table", "tablespace", "temp", "temporary", "to",
        "unique", "unlogged", "update", "using", "values", "virtual", "where",
        "with", "without"
    };

    // keyword length in characters
    function automatic int kw_len(input int k);
        logic [8*KW_CHARS-1:0] e;
        int n;
        e = KW_TABLE[k];
        n = 0;
        for (int p = 0; p < KW_CHARS; p++) begin
            if (e[8*p +: 8] != 8'd0) begin
                n = p + 1;
            end
        end
        return n;
    endfunction

    // character at a position of a keyword, zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [8*KW_CHARS-1:0] e;
        int l;
        e = KW_TABLE[k];
        l = kw_len(k);
        if (int'(pos) >= l) begin
            return 8'd0;
        end
        return e[8*(l - 1 - int'(pos)) +: 8];
    endfunction

    // character classes
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    // punctuation kind, error kind when not punctuation
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            ".":     k = KIND_DOT;
            "=":     k = KIND_EQUAL;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/sdt_front.sv
`timescale 1ns / 1ps
// scanner front end: accepts bytes, runs the lexer state and builds event bundles
// depends on sdt_pkg

module sdt_front import sdt_pkg::*; #(
    parameter int COUNT_WIDTH       = DEF_COUNT_WIDTH,
    parameter int MAX_KEYWORD_CHARS = DEF_MAX_KEYWORD_CHARS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_tok_in i_in_data,
    input  logic    i_q_full,
    output logic    o_push,
    output t_bundle o_bundle
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef struct packed {
        t_scan_mode                 mode;
        logic [7:0]                 pend;
        logic [31:0]                off;
        logic [31:0]                tstart;
        logic [COUNT_WIDTH-1:0]     tlen;
        logic [COUNT_WIDTH-1:0]     line;
        logic [COUNT_WIDTH-1:0]     col;
        logic [COUNT_WIDTH-1:0]     tline;
        logic [COUNT_WIDTH-1:0]     tcol;
        logic [KW_ENTRIES-1:0]      cand;
    } t_scan;

    typedef struct packed {
        t_scan   s;
        t_bundle b;
    } t_work;

    t_scan   r_scan;
    t_scan   n_scan;
    t_bundle n_bundle;
    logic    accept;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
        return (x != CNT_MAX) ? x + CNT_ONE : x;
    endfunction

    function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] x);
        logic [32:0] wide;
        wide = 33'(x);
        return (wide > 33'd65535) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic t_scan consume(input t_scan s, input logic [7:0] c);
        s.off = s.off + 32'd1;
        if (c == 8'h0A) begin
            s.line = sat_inc(s.line);
            s.col  = CNT_ONE;
        end else begin
            s.col = sat_inc(s.col);
        end
        s.tlen = sat_inc(s.tlen);
        return s;
    endfunction

    function automatic t_scan begin_token(input t_scan s);
        s.tstart = s.off;
        s.tline  = s.line;
        s.tcol   = s.col;
        s.tlen   = '0;
        s.cand   = '1;
        return s;
    endfunction

    // drop keywords that disagree at the current position
    function automatic t_scan narrow(input t_scan s, input logic [7:0] c);
        logic [7:0] lc;
        logic       past;
        lc   = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
        past = (33'(s.tlen) >= 33'(MAX_KEYWORD_CHARS));
        for (int k = 0; k < KW_ENTRIES; k++) begin
            if (past || (kw_char(k, s.tlen[3:0]) != lc)) begin
                s.cand[k] = 1'b0;
            end
        end
        return s;
    endfunction

    function automatic t_work emit(input t_work w, input logic [3:0] kind,
                                   input logic [6:0] kw, input logic [1:0] err,
                                   input logic [7:0] bad);
        t_tok_out e;
        e.token_kind    = kind;
        e.keyword_index = kw;
        e.start_offset  = w.s.tstart;
        e.token_length  = sat16(w.s.tlen);
        e.start_line    = sat16(w.s.tline);
        e.start_column  = sat16(w.s.tcol);
        e.error_code    = err;
        e.bad_char      = bad;
        e.last_of_run   = 1'b0;
        if (w.b.cnt != 2'd3) begin
            w.b.ev[w.b.cnt] = e;
            w.b.cnt = w.b.cnt + 2'd1;
        end
        return w;
    endfunction

    // exact match: at most one surviving candidate has the token's length
    function automatic t_work finish_ident(input t_work w);
        logic [KW_ENTRIES-1:0] match;
        logic [6:0]            idx;
        for (int k = 0; k < KW_ENTRIES; k++) begin
            match[k] = w.s.cand[k] && (33'(kw_len(k)) == 33'(w.s.tlen));
        end
        idx = '0;
        for (int k = 0; k < KW_ENTRIES; k++) begin
            idx = idx | (match[k] ? 7'(k) : 7'd0);
        end
        if ((33'(w.s.tlen) <= 33'(MAX_KEYWORD_CHARS)) && (|match)) begin
            return emit(w, KIND_KEYWORD, idx, ERR_NONE, 8'd0);
        end
        return emit(w, KIND_IDENT, 7'd0, ERR_NONE, 8'd0);
    endfunction

    function automatic t_work start_byte(input t_work w, input logic [7:0] c);
        logic [3:0] pk;
        w.s.mode = SCAN_IDLE;
        w.s.pend = 8'd0;
        if ((c == " ") || (c == 8'h0D) || (c == 8'h09) || (c == 8'h0A)) begin
            w.s = consume(w.s, c);
            return w;
        end
        w.s = begin_token(w.s);
        if ((c == "-") || (c == "/") || (c == ":")) begin
            w.s.mode = (c == "-") ? SCAN_DASH : ((c == "/") ? SCAN_SLASH : SCAN_COLON);
            w.s.pend = c;
            return w;
        end
        if (is_alpha(c) || (c == "_")) begin
            w.s = narrow(w.s, c);
            w.s = consume(w.s, c);
            w.s.mode = SCAN_IDENT;
            return w;
        end
        w.s = consume(w.s, c);
        pk = punct_kind(c);
        if (is_digit(c)) begin
            w.s.mode = SCAN_INT;
        end else if (c == "\"") begin
            w.s.mode = SCAN_QID;
        end else if (c == "'") begin
            w.s.mode = SCAN_STR;
        end else if (pk != KIND_ERROR) begin
            w = emit(w, pk, 7'd0, ERR_NONE, 8'd0);
        end else begin
            w = emit(w, KIND_ERROR, 7'd0, ERR_CHAR, c);
        end
        return w;
    endfunction

    function automatic t_work lone_error(input t_work w);
        logic [7:0] p;
        p = w.s.pend;
        w.s = consume(w.s, p);
        return emit(w, KIND_ERROR, 7'd0, ERR_CHAR, p);
    endfunction

    function automatic t_work number_then_dot(input t_work w);
        w = emit(w, KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
        w.s = begin_token(w.s);
        w.s = consume(w.s, ".");
        return emit(w, KIND_DOT, 7'd0, ERR_NONE, 8'd0);
    endfunction

    function automatic t_work step_byte(input t_work w, input logic [7:0] c);
        t_scan_mode m;
        m = w.s.mode;
        case (m)
            SCAN_IDLE: begin
                w = start_byte(w, c);
            end
            SCAN_DASH, SCAN_SLASH: begin
                if (((m == SCAN_DASH) && (c == "-")) || ((m == SCAN_SLASH) && (c == "*"))) begin
                    w.s = consume(w.s, w.s.pend);
                    w.s = consume(w.s, c);
                    w.s.pend = 8'd0;
                    w.s.mode = (m == SCAN_DASH) ? SCAN_LINECMT : SCAN_BLOCK;
                end else begin
                    w = lone_error(w);
                    w = start_byte(w, c);
                end
            end
            SCAN_COLON: begin
                if (c == ":") begin
                    w.s = consume(w.s, ":");
                    w.s = consume(w.s, c);
                    w.s.pend = 8'd0;
                    w.s.mode = SCAN_IDLE;
                    w = emit(w, KIND_DCOLON, 7'd0, ERR_NONE, 8'd0);
                end else begin
                    w = lone_error(w);
                    w = start_byte(w, c);
                end
            end
            SCAN_NUMDOT: begin
                if (is_digit(c)) begin
                    w.s = consume(w.s, ".");
                    w.s = consume(w.s, c);
                    w.s.pend = 8'd0;
                    w.s.mode = SCAN_FRAC;
                end else begin
                    w = number_then_dot(w);
                    w = start_byte(w, c);
                end
            end
            SCAN_IDENT: begin
                if (is_word(c)) begin
                    w.s = narrow(w.s, c);
                    w.s = consume(w.s, c);
                end else begin
                    w = finish_ident(w);
                    w = start_byte(w, c);
                end
            end
            SCAN_INT, SCAN_FRAC: begin
                if (is_digit(c)) begin
                    w.s = consume(w.s, c);
                end else if ((c == ".") && (m == SCAN_INT)) begin
                    w.s.mode = SCAN_NUMDOT;
                    w.s.pend = c;
                end else if ((c == "e") || (c == "E")) begin
                    w.s = consume(w.s, c);
                    w.s.mode = SCAN_EXP0;
                end else begin
                    w = emit(w, KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
                    w = start_byte(w, c);
                end
            end
            SCAN_EXP0: begin
                if ((c == "+") || (c == "-") || is_digit(c)) begin
                    w.s = consume(w.s, c);
                    w.s.mode = SCAN_EXPD;
                end else begin
                    w = emit(w, KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
                    w = start_byte(w, c);
                end
            end
            SCAN_EXPD: begin
                if (is_digit(c)) begin
                    w.s = consume(w.s, c);
                end else begin
                    w = emit(w, KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
                    w = start_byte(w, c);
                end
            end
            SCAN_QID: begin
                w.s = consume(w.s, c);
                if (c == "\"") begin
                    w.s.mode = SCAN_QIDEND;
                end
            end
            SCAN_QIDEND: begin
                if (c == "\"") begin
                    w.s = consume(w.s, c);
                    w.s.mode = SCAN_QID;
                end else begin
                    w = emit(w, KIND_IDENT, 7'd0, ERR_NONE, 8'd0);
                    w = start_byte(w, c);
                end
            end
            SCAN_STR: begin
                w.s = consume(w.s, c);
                if (c == "'") begin
                    w.s.mode = SCAN_STREND;
                end else if (c == "\\") begin
                    w.s.mode = SCAN_STRESC;
                end
            end
            SCAN_STRESC: begin
                w.s = consume(w.s, c);
                w.s.mode = SCAN_STR;
            end
            SCAN_STREND: begin
                if (c == "'") begin
                    w.s = consume(w.s, c);
                    w.s.mode = SCAN_STR;
                end else begin
                    w = emit(w, KIND_STRING, 7'd0, ERR_NONE, 8'd0);
                    w = start_byte(w, c);
                end
            end
            SCAN_LINECMT: begin
                if (c == 8'h0A) begin
                    w = start_byte(w, c);
                end else begin
                    w.s = consume(w.s, c);
                end
            end
            SCAN_BLOCK: begin
                w.s = consume(w.s, c);
                if (c == "*") begin
                    w.s.mode = SCAN_BLOCKSTAR;
                end
            end
            SCAN_BLOCKSTAR: begin
                w.s = consume(w.s, c);
                if (c == "/") begin
                    w.s.mode = SCAN_IDLE;
                end else if (c != "*") begin
                    w.s.mode = SCAN_BLOCK;
                end
            end
            default: begin
                w = start_byte(w, c);
            end
        endcase
        return w;
    endfunction

    function automatic t_work step_end(input t_work w);
        case (w.s.mode)
            SCAN_DASH, SCAN_SLASH, SCAN_COLON: w = lone_error(w);
            SCAN_NUMDOT:                      w = number_then_dot(w);
            SCAN_IDENT:                       w = finish_ident(w);
            SCAN_INT, SCAN_FRAC, SCAN_EXP0, SCAN_EXPD:
                w = emit(w, KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
            SCAN_QID:     w = emit(w, KIND_ERROR, 7'd0, ERR_QID, 8'd0);
            SCAN_QIDEND:  w = emit(w, KIND_IDENT, 7'd0, ERR_NONE, 8'd0);
            SCAN_STR, SCAN_STRESC:
                w = emit(w, KIND_ERROR, 7'd0, ERR_STR, 8'd0);
            SCAN_STREND:  w = emit(w, KIND_STRING, 7'd0, ERR_NONE, 8'd0);
            default:      w = w;
        endcase
        w.s = begin_token(w.s);
        w = emit(w, KIND_END, 7'd0, ERR_NONE, 8'd0);
        w.s.mode = SCAN_IDLE;
        w.s.pend = 8'd0;
        w.s.off  = 32'd0;
        w.s.line = CNT_ONE;
        w.s.col  = CNT_ONE;
        return w;
    endfunction

    // one byte or end marker through the lexer
    always_comb begin
        t_work w;
        w.s = r_scan;
        w.b = '0;
        if (i_in_data.end_of_text) begin
            w = step_end(w);
        end else begin
            w = step_byte(w, i_in_data.text_byte);
        end
        if (w.b.cnt != 2'd0) begin
            w.b.ev[w.b.cnt - 2'd1].last_of_run = 1'b1;
        end
        n_scan   = w.s;
        n_bundle = w.b;
    end

    // handshake toward the queue
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (n_bundle.cnt != 2'd0);
    assign o_bundle   = n_bundle;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.mode   <= SCAN_IDLE;
            r_scan.pend   <= 8'd0;
            r_scan.off    <= 32'd0;
            r_scan.tstart <= 32'd0;
            r_scan.tlen   <= '0;
            r_scan.line   <= CNT_ONE;
            r_scan.col    <= CNT_ONE;
            r_scan.tline  <= CNT_ONE;
            r_scan.tcol   <= CNT_ONE;
            r_scan.cand   <= '1;
        end else if (accept) begin
            r_scan <= n_scan;
        end
    end

endmodule

FILE: hw/rtl/sdt_queue.sv
`timescale 1ns / 1ps
// bundle queue between scanner front end and event back end
// depends on sdt_pkg

module sdt_queue import sdt_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    t_bundle         r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == DEPTH_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/sdt_back.sv
`timescale 1ns / 1ps
// event back end: walks each bundle and hands events to the output register
// depends on sdt_pkg

module sdt_back import sdt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_bundle  i_head,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_tok_out o_out_data
);

    logic [1:0] r_sub;
    logic       r_valid;
    t_tok_out   r_data;
    logic       take;
    logic       at_last;

    // load output register when it is empty or its transfer completes
    assign take    = !i_empty && (!r_valid || i_out_ready);
    assign at_last = (r_sub == (i_head.cnt - 2'd1));
    assign o_pop   = take && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_sub   <= at_last ? 2'd0 : r_sub + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= i_head.ev[r_sub];
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

FILE: hw/rtl/sql_ddl_tokenizer_unit.sv
`timescale 1ns / 1ps
// top level of the sql ddl tokenizer: front scanner, bundle queue, event back end
// depends on sdt_pkg, sdt_front, sdt_queue, sdt_back
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | i_in_data  (t_tok_in)
//  output  | out       | o_out_valid / i_out_ready  | o_out_data (t_tok_out)
//
// one byte is taken per cycle while the queue is not full; each byte yields zero to
// three events, one queue entry if any; the back end sends one event per cycle
// from the output register while i_out_ready is high; events pass through the queue
// first. the input stalls only when all QUEUE_DEPTH entries hold unpopped bundles.
// reset is synchronous, active low, and puts the scanner between tokens at line 1.

module sql_ddl_tokenizer_unit import sdt_pkg::*; #(
    parameter int COUNT_WIDTH       = DEF_COUNT_WIDTH,
    parameter int MAX_KEYWORD_CHARS = DEF_MAX_KEYWORD_CHARS,
    parameter int QUEUE_DEPTH       = DEF_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_tok_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_tok_out o_out_data
);

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_bundle q_in;
    t_bundle q_head;

    // scanner
    sdt_front #(
        .COUNT_WIDTH      (COUNT_WIDTH),
        .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data (i_in_data),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_bundle  (q_in)
    );

    // decoupling queue
    sdt_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    // event output
    sdt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

FILE: dv/sdt_checker.sv
`timescale 1ns / 1ps
// token event checker for the sql ddl tokenizer: watches both channels, predicts events
// from accepted bytes and compares them in order; depends on sdt_pkg

module sdt_checker import sdt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_tok_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_tok_out i_out_data,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_event_count
);

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // scanner state copy
    t_scan_mode  mode;
    logic [7:0]  held_byte;
    logic [31:0] offset;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [KW_ENTRIES-1:0] kw_alive;

    t_tok_out expected_events [$];
    int       step_events;

    function automatic logic [15:0] sat_inc(input logic [15:0] x);
        return (x == CNT_MAX) ? x : x + 16'd1;
    endfunction

    // keyword table entry char, read from the right-aligned package table
    function automatic logic [7:0] kw_at(input int k, input int pos);
        logic [8*KW_CHARS-1:0] e;
        int n;
        e = KW_TABLE[k];
        n = 0;
        for (int p = 0; p < KW_CHARS; p++) if (e[8*p +: 8] != 8'd0) n = p + 1;
        if (pos >= n) return 8'd0;
        return e[8*(n - 1 - pos) +: 8];
    endfunction

    function automatic logic dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic push_event(input logic [3:0] kind, input logic [6:0] kw,
                              input logic [1:0] err, input logic [7:0] bad);
        t_tok_out e;
        e.token_kind    = kind;
        e.keyword_index = kw;
        e.start_offset  = tok_start;
        e.token_length  = tok_len;
        e.start_line    = tok_line;
        e.start_column  = tok_col;
        e.error_code    = err;
        e.bad_char      = bad;
        e.last_of_run   = 1'b0;
        expected_events.push_back(e);
        step_events++;
    endtask

    task automatic open_token();
        tok_start = offset;
        tok_line  = line_no;
        tok_col   = col_no;
        tok_len   = '0;
        kw_alive  = '1;
    endtask

    task automatic take(input logic [7:0] c);
        offset = offset + 32'd1;
        if (c == 8'h0A) begin
            line_no = sat_inc(line_no);
            col_no  = 16'd1;
        end else begin
            col_no = sat_inc(col_no);
        end
        tok_len = sat_inc(tok_len);
    endtask

    task automatic narrow_keywords(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        for (int k = 0; k < KW_ENTRIES; k++)
            if (tok_len >= 16'(KW_CHARS) || kw_at(k, int'(tok_len)) != lc) kw_alive[k] = 1'b0;
    endtask

    task automatic close_word();
        if (tok_len <= 16'(KW_CHARS)) begin
            for (int k = 0; k < KW_ENTRIES; k++) begin
                if (kw_alive[k] && kw_at(k, int'(tok_len)) == 8'd0) begin
                    push_event(KIND_KEYWORD, 7'(k), ERR_NONE, 8'd0);
                    return;
                end
            end
        end
        push_event(KIND_IDENT, 7'd0, ERR_NONE, 8'd0);
    endtask

    task automatic fresh_byte(input logic [7:0] c);
        logic [3:0] pk;
        mode = SCAN_IDLE;
        held_byte = 8'd0;
        if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
            take(c);
            return;
        end
        open_token();
        if (c == "-" || c == "/" || c == ":") begin
            mode = (c == "-") ? SCAN_DASH : (c == "/") ? SCAN_SLASH : SCAN_COLON;
            held_byte = c;
            return;
        end
        if (alpha(c) || c == "_") begin
            narrow_keywords(c);
            take(c);
            mode = SCAN_IDENT;
            return;
        end
        take(c);
        if (dig(c)) mode = SCAN_INT;
        else if (c == "\"") mode = SCAN_QID;
        else if (c == "'") mode = SCAN_STR;
        else begin
            case (c)
                "(": pk = KIND_LPAREN;
                ")": pk = KIND_RPAREN;
                ",": pk = KIND_COMMA;
                ";": pk = KIND_SEMI;
                ".": pk = KIND_DOT;
                "=": pk = KIND_EQUAL;
                "[": pk = KIND_LBRACKET;
                "]": pk = KIND_RBRACKET;
                default: pk = KIND_ERROR;
            endcase
            if (pk == KIND_ERROR) push_event(KIND_ERROR, 7'd0, ERR_CHAR, c);
            else push_event(pk, 7'd0, ERR_NONE, 8'd0);
        end
    endtask

    task automatic stray_lead();
        logic [7:0] p;
        p = held_byte;
        take(p);
        push_event(KIND_ERROR, 7'd0, ERR_CHAR, p);
    endtask

    task automatic number_dot();
        push_event(KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
        open_token();
        take(".");
        push_event(KIND_DOT, 7'd0, ERR_NONE, 8'd0);
    endtask

    task automatic scan_byte(input logic [7:0] c);
        case (mode)
            SCAN_DASH, SCAN_SLASH: begin
                if ((mode == SCAN_DASH && c == "-") || (mode == SCAN_SLASH && c == "*")) begin
                    take(held_byte);
                    take(c);
                    held_byte = 8'd0;
                    mode = (mode == SCAN_DASH) ? SCAN_LINECMT : SCAN_BLOCK;
                end else begin
                    stray_lead();
                    fresh_byte(c);
                end
            end
            SCAN_COLON: begin
                if (c == ":") begin
                    take(":");
                    take(c);
                    held_byte = 8'd0;
                    mode = SCAN_IDLE;
                    push_event(KIND_DCOLON, 7'd0, ERR_NONE, 8'd0);
                end else begin
                    stray_lead();
                    fresh_byte(c);
                end
            end
            SCAN_NUMDOT: begin
                if (dig(c)) begin
                    take(".");
                    take(c);
                    held_byte = 8'd0;
                    mode = SCAN_FRAC;
                end else begin
                    number_dot();
                    fresh_byte(c);
                end
            end
            SCAN_IDENT: begin
                if (alpha(c) || dig(c) || c == "_") begin
                    narrow_keywords(c);
                    take(c);
                end else begin
                    close_word();
                    fresh_byte(c);
                end
            end
            SCAN_INT, SCAN_FRAC: begin
                if (dig(c)) take(c);
                else if (c == "." && mode == SCAN_INT) begin
                    mode = SCAN_NUMDOT;
                    held_byte = c;
                end else if (c == "e" || c == "E") begin
                    take(c);
                    mode = SCAN_EXP0;
                end else begin
                    push_event(KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
                    fresh_byte(c);
                end
            end
            SCAN_EXP0: begin
                if (c == "+" || c == "-" || dig(c)) begin
                    take(c);
                    mode = SCAN_EXPD;
                end else begin
                    push_event(KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
                    fresh_byte(c);
                end
            end
            SCAN_EXPD: begin
                if (dig(c)) take(c);
                else begin
                    push_event(KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
                    fresh_byte(c);
                end
            end
            SCAN_QID: begin
                take(c);
                if (c == "\"") mode = SCAN_QIDEND;
            end
            SCAN_QIDEND: begin
                if (c == "\"") begin
                    take(c);
                    mode = SCAN_QID;
                end else begin
                    push_event(KIND_IDENT, 7'd0, ERR_NONE, 8'd0);
                    fresh_byte(c);
                end
            end
            SCAN_STR: begin
                take(c);
                if (c == "'") mode = SCAN_STREND;
                else if (c == "\\") mode = SCAN_STRESC;
            end
            SCAN_STRESC: begin
                take(c);
                mode = SCAN_STR;
            end
            SCAN_STREND: begin
                if (c == "'") begin
                    take(c);
                    mode = SCAN_STR;
                end else begin
                    push_event(KIND_STRING, 7'd0, ERR_NONE, 8'd0);
                    fresh_byte(c);
                end
            end
            SCAN_LINECMT: begin
                if (c == 8'h0A) fresh_byte(c);
                else take(c);
            end
            SCAN_BLOCK: begin
                take(c);
                if (c == "*") mode = SCAN_BLOCKSTAR;
            end
            SCAN_BLOCKSTAR: begin
                take(c);
                if (c == "/") mode = SCAN_IDLE;
                else if (c != "*") mode = SCAN_BLOCK;
            end
            default: fresh_byte(c);
        endcase
    endtask

    task automatic scan_end();
        case (mode)
            SCAN_DASH, SCAN_SLASH, SCAN_COLON: stray_lead();
            SCAN_NUMDOT: number_dot();
            SCAN_IDENT: close_word();
            SCAN_INT, SCAN_FRAC, SCAN_EXP0, SCAN_EXPD:
                push_event(KIND_NUMBER, 7'd0, ERR_NONE, 8'd0);
            SCAN_QID: push_event(KIND_ERROR, 7'd0, ERR_QID, 8'd0);
            SCAN_QIDEND: push_event(KIND_IDENT, 7'd0, ERR_NONE, 8'd0);
            SCAN_STR, SCAN_STRESC: push_event(KIND_ERROR, 7'd0, ERR_STR, 8'd0);
            SCAN_STREND: push_event(KIND_STRING, 7'd0, ERR_NONE, 8'd0);
            default: ;
        endcase
        open_token();
        push_event(KIND_END, 7'd0, ERR_NONE, 8'd0);
        mode = SCAN_IDLE;
        held_byte = 8'd0;
        offset = '0;
        line_no = 16'd1;
        col_no = 16'd1;
    endtask

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_tok_out exp_ev;
        t_tok_out last_ev;
        if (!i_rst_n) begin
            mode = SCAN_IDLE;
            held_byte = 8'd0;
            offset = '0;
            line_no = 16'd1;
            col_no = 16'd1;
            open_token();
            expected_events.delete();
            o_fail_count <= 0;
            o_event_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_event_count <= o_event_count + 1;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, actual %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (exp_ev !== i_out_data) begin
                        $display("%0t: event mismatch, expected %p, actual %p",
                                 $time, exp_ev, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_events = 0;
                if (i_in_data.end_of_text) scan_end();
                else scan_byte(i_in_data.text_byte);
                if (step_events > 0) begin
                    last_ev = expected_events.pop_back();
                    last_ev.last_of_run = 1'b1;
                    expected_events.push_back(last_ev);
                end
            end
            o_pending <= expected_events.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the sql ddl tokenizer: sql-like byte streams with random gaps
// depends on sdt_pkg, sql_ddl_tokenizer_unit and sdt_checker

module testbench;
    import sdt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_tok_in  in_data;
    logic     out_valid;
    logic     out_ready;
    t_tok_out out_data;
    int       fail_count;
    int       pending;
    int       event_count;
    int       bytes_sent;
    int       idle_cycles;
    logic     stall_enable;

    sql_ddl_tokenizer_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    sdt_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_event_count(event_count)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver stalls, off during quiet stretches
    always @(posedge clk) begin
        if (!rst_n || !stall_enable) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 99) < 70) ||
                          ($urandom_range(0, 99) < 5 && !out_ready);
    end

    // watchdog on transfers
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one byte transfer with an optional gap first; valid stays high when no gap follows
    task automatic send_item(input logic [7:0] b, input logic eot, input logic gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.text_byte <= b;
        in_data.end_of_text <= eot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic gaps);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, gaps);
    endtask

    task automatic end_text(input logic gaps);
        send_item(8'($urandom_range(0, 255)), 1'b1, gaps);
    endtask

    // a random sql-like fragment, mostly well formed
    function automatic string fragment();
        string words [12] = '{"create", "TABLE", "Without", "compression", "action",
                              "x_1", "partitions", "tablespace", "nulls", "a", "_q", "Key"};
        string parts [16] = '{"(", ")", ",", ";", ".", "=", "[", "]", "::", " ", "\n",
                              "-- note\n", "/* c * / */", "\t", "\r", "'it''s'"};
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return words[$urandom_range(0, 11)];
        if (r < 50) return $sformatf("%0d", $urandom_range(0, 99999));
        if (r < 55) return "1.5e+3";
        if (r < 58) return "7.x";
        if (r < 62) return "\"q\"\"d\"";
        if (r < 65) return "'a\\'b'";
        if (r < 90) return parts[$urandom_range(0, 15)];
        return $sformatf("%c", 8'($urandom_range(0, 255)));
    endfunction

    initial begin
        string t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        stall_enable = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: keywords at table edges, punctuation, comments, numbers, quotes
        send_text("ACTION without(x)", 1'b0);
        end_text(1'b0);
        send_text("a::b;-/:=[].,", 1'b0);
        end_text(1'b0);
        send_text("1.e 2.5E-3 1e", 1'b0);
        end_text(1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        end_text(1'b0);
        send_text("7.", 1'b0);
        end_text(1'b0);
        send_text("'open\n\\", 1'b0);
        end_text(1'b0);
        send_text("\"qid", 1'b0);
        end_text(1'b0);
        send_text("/* never closed", 1'b0);
        end_text(1'b0);
        in_valid <= 1'b0;

        // pause until the block has drained
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // random streams with gaps on both sides, some stretches without
        stall_enable = 1'b1;
        while (bytes_sent < 200) begin
            stall_enable = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 8)) begin
                t = fragment();
                send_text(t, stall_enable);
            end
            if ($urandom_range(0, 2) == 0) send_text(" 'x", 1'b1);
            end_text(1'b1);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d items including directed keyword, number, quote, comment", bytes_sent);
        $display("and bad-byte cases; checked %0d token events", event_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sql_ddl_tokenizer_unit.f
hw/rtl/sdt_pkg.sv
hw/rtl/sdt_front.sv
hw/rtl/sdt_queue.sv
hw/rtl/sdt_back.sv
hw/rtl/sql_ddl_tokenizer_unit.sv
dv/sdt_checker.sv
dv/testbench.sv
